### hw/rtl/tes_pkg.sv
package tes_pkg;

  localparam int unsigned IdW      = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned IvW      = 31;
  localparam int unsigned MaxFires = 16;
  localparam int unsigned FireCntW = $clog2(MaxFires);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ADD_AT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_NOT_FUTURE = 3'd1,
    ST_FULL       = 3'd2,
    ST_DELETED    = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_FIRED      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_DSCAN,
    S_DEMIT,
    S_TSCAN,
    S_TDEC,
    S_TEMIT_MORE,
    S_TUPD,
    S_TEMIT_LAST
  } ctrl_state_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] expire;
    logic [IvW-1:0]   period;
  } slot_t;

  typedef struct packed {
    logic in_ready;
    logic scan_clr;
    logic scan_run;
    logic time_inc;
    logic do_add;
    logic del_emit;
    logic fire_upd;
    logic fire_emit;
    logic fire_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    cmd_e in_cmd;
    logic out_free;
    logic scan_done;
    logic best_found;
    logic pend_valid;
    logic fire_full;
  } ctl_stat_t;

endpackage

### hw/rtl/tes_in_if.sv
interface tes_in_if;
  import tes_pkg::*;

  logic             valid;
  logic             ready;
  cmd_e             command;
  logic [IvW-1:0]   delay_ms;
  logic [IvW-1:0]   period_ms;
  logic [TimeW-1:0] absolute_time;
  logic [IdW-1:0]   target_id;

  modport source (
    output valid, command, delay_ms, period_ms, absolute_time, target_id,
    input  ready
  );

  modport sink (
    input  valid, command, delay_ms, period_ms, absolute_time, target_id,
    output ready
  );
endinterface

### hw/rtl/tes_out_if.sv
interface tes_out_if;
  import tes_pkg::*;

  logic           valid;
  logic           ready;
  logic [IdW-1:0] result_id;
  status_e        status;
  logic           last;

  modport source (
    output valid, result_id, status, last,
    input  ready
  );

  modport sink (
    input  valid, result_id, status, last,
    output ready
  );
endinterface

### hw/rtl/timer_expiry_scheduler.sv
// add: the result word is registered in S_ADD once the output register is free
// delete: one pass over the slot store, then the result word
// tick: one pass over the slot store per fired timer, up to 16 fired per tick;
//   the slot store has a single read port
// one command at a time; the next is taken as soon as the last result is registered
// reset: all slots free, time zero, next id one; slot contents are not cleared
module timer_expiry_scheduler #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tes_in_if.sink    in_i,
  tes_out_if.source out_o
);
  import tes_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  tes_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tes_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

### hw/rtl/tes_ctrl.sv
module tes_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tes_pkg::ctl_stat_t stat_i,
  output tes_pkg::ctl_cmd_t  cmd_o
);
  import tes_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.in_valid) begin
          if (stat_i.in_cmd == CMD_DELETE) begin
            state_d = S_DSCAN;
          end else if (stat_i.in_cmd == CMD_TICK) begin
            state_d = S_TSCAN;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_ADD: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_DSCAN: begin
        if (stat_i.scan_done) state_d = S_DEMIT;
      end
      S_DEMIT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_TSCAN: begin
        if (stat_i.scan_done) state_d = S_TDEC;
      end
      S_TDEC: begin
        // a held word goes out only once we know whether another follows
        if (stat_i.best_found && stat_i.pend_valid) begin
          state_d = S_TEMIT_MORE;
        end else if (stat_i.best_found) begin
          state_d = S_TUPD;
        end else if (stat_i.pend_valid) begin
          state_d = S_TEMIT_LAST;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TEMIT_MORE: begin
        if (stat_i.out_free) state_d = S_TUPD;
      end
      S_TUPD: begin
        state_d = stat_i.fire_full ? S_TEMIT_LAST : S_TSCAN;
      end
      S_TEMIT_LAST: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.scan_clr = (stat_i.in_cmd == CMD_DELETE) || (stat_i.in_cmd == CMD_TICK);
          cmd_o.time_inc = (stat_i.in_cmd == CMD_TICK);
        end
      end
      S_ADD:        cmd_o.do_add   = stat_i.out_free;
      S_DSCAN:      cmd_o.scan_run = 1'b1;
      S_DEMIT:      cmd_o.del_emit = stat_i.out_free;
      S_TSCAN:      cmd_o.scan_run = 1'b1;
      S_TDEC:       cmd_o = '0;
      S_TEMIT_MORE: cmd_o.fire_emit = stat_i.out_free;
      S_TUPD: begin
        cmd_o.fire_upd = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      S_TEMIT_LAST: begin
        cmd_o.fire_emit = stat_i.out_free;
        cmd_o.fire_last = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### hw/rtl/tes_datapath.sv
module tes_datapath #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tes_pkg::ctl_cmd_t cmd_i,
  output tes_pkg::ctl_stat_t stat_o,
  tes_in_if.sink            in_i,
  tes_out_if.source         out_o
);
  import tes_pkg::*;

  localparam int unsigned AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);

  // latched command word
  cmd_e             cmd_q;
  logic [IvW-1:0]   delay_q;
  logic [IvW-1:0]   period_q;
  logic [TimeW-1:0] mark_q;
  logic [IdW-1:0]   target_q;

  logic [TIMER_SLOTS-1:0] valid_q, valid_d;
  logic [TimeW-1:0]       now_q;
  logic [IdW-1:0]         next_id_q, next_id_inc;

  slot_t          mem_q [TIMER_SLOTS];
  slot_t          rd_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  slot_t          mem_wdata;

  logic [CW-1:0]  scan_addr_q;
  logic           rd_vld_q;
  logic [AW-1:0]  rd_idx_q;
  logic           rd_issue;

  logic             best_found_q;
  logic [TimeW-1:0] best_age_q;
  logic [IdW-1:0]   best_id_q;
  logic [AW-1:0]    best_slot_q;
  logic [IvW-1:0]   best_period_q;
  logic             del_found_q;

  logic [FireCntW-1:0] fire_cnt_q;
  logic                pend_valid_q;
  logic [IdW-1:0]      pend_id_q;

  logic           out_valid_q;
  logic [IdW-1:0] out_id_q;
  status_e        out_status_q;
  logic           out_last_q;
  logic           out_free;
  logic           out_load;
  logic [IdW-1:0] load_id;
  status_e        load_status;
  logic           load_last;

  logic             accept;
  logic [AW-1:0]    free_idx;
  logic             free_hit;
  logic [TimeW-1:0] mark_diff;
  logic             reject_time;
  logic             add_arm;
  logic [TimeW-1:0] add_expire;
  logic [IvW-1:0]   add_period;
  logic             hit_valid;
  logic [TimeW-1:0] age;
  logic             better;
  logic             tick_take;
  logic             del_hit;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_i.command;
      delay_q  <= in_i.delay_ms;
      period_q <= in_i.period_ms;
      mark_q   <= in_i.absolute_time;
      target_q <= in_i.target_id;
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_hit = 1'b0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = AW'(i);
        free_hit = 1'b1;
      end
    end
  end

  // an absolute mark must lie strictly ahead, wrap-aware
  assign mark_diff   = mark_q - now_q;
  assign reject_time = (cmd_q == CMD_ADD_AT) && ((mark_diff == '0) || mark_diff[TimeW-1]);
  assign add_arm     = cmd_i.do_add && !reject_time && free_hit;
  assign add_expire  = (cmd_q == CMD_ADD_AT) ? mark_q : now_q + TimeW'(delay_q);
  assign add_period  = (cmd_q == CMD_ADD_AT) ? '0 : period_q;
  assign next_id_inc = next_id_q + IdW'(1);

  // scan compare on the registered read
  assign hit_valid = rd_vld_q && valid_q[rd_idx_q];
  assign age       = now_q - rd_q.expire;
  assign better    = !best_found_q || (age > best_age_q) ||
                     ((age == best_age_q) && (rd_q.id < best_id_q));
  assign tick_take = hit_valid && (cmd_q == CMD_TICK) && !age[TimeW-1] && better;
  assign del_hit   = hit_valid && (cmd_q == CMD_DELETE) && (rd_q.id == target_q);
  assign rd_issue  = cmd_i.scan_run && (scan_addr_q != CW'(TIMER_SLOTS));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = '{id: next_id_q, expire: add_expire, period: add_period};
    if (add_arm) begin
      mem_we = 1'b1;
    end else if (cmd_i.fire_upd && (best_period_q != '0)) begin
      mem_we    = 1'b1;
      mem_waddr = best_slot_q;
      mem_wdata = '{id: best_id_q, expire: now_q + TimeW'(best_period_q),
                    period: best_period_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (rd_issue) rd_q <= mem_q[scan_addr_q[AW-1:0]];
  end

  always_comb begin
    valid_d = valid_q;
    if (add_arm) valid_d[free_idx] = 1'b1;
    if (del_hit) valid_d[rd_idx_q] = 1'b0;
    if (cmd_i.fire_upd && (best_period_q == '0)) valid_d[best_slot_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      now_q        <= '0;
      next_id_q    <= IdW'(1);
      scan_addr_q  <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      best_found_q <= 1'b0;
      del_found_q  <= 1'b0;
      fire_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.time_inc) now_q <= now_q + TimeW'(1);
      if (add_arm) next_id_q <= (next_id_inc == '0) ? IdW'(1) : next_id_inc;
      rd_vld_q <= rd_issue;
      if (rd_issue) begin
        rd_idx_q    <= scan_addr_q[AW-1:0];
        scan_addr_q <= scan_addr_q + CW'(1);
      end
      if (tick_take) best_found_q <= 1'b1;
      if (del_hit) del_found_q <= 1'b1;
      if (cmd_i.scan_clr) begin
        scan_addr_q  <= '0;
        best_found_q <= 1'b0;
        del_found_q  <= 1'b0;
      end
      if (cmd_i.time_inc) begin
        fire_cnt_q   <= '0;
        pend_valid_q <= 1'b0;
      end else if (cmd_i.fire_upd) begin
        fire_cnt_q   <= fire_cnt_q + FireCntW'(1);
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_take) begin
      best_age_q    <= age;
      best_id_q     <= rd_q.id;
      best_slot_q   <= rd_idx_q;
      best_period_q <= rd_q.period;
    end
    if (cmd_i.fire_upd) pend_id_q <= best_id_q;
  end

  // output word register
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = cmd_i.do_add || cmd_i.del_emit || cmd_i.fire_emit;

  always_comb begin
    load_id     = pend_id_q;
    load_status = ST_FIRED;
    load_last   = cmd_i.fire_last;
    if (cmd_i.do_add) begin
      load_last = 1'b1;
      if (reject_time) begin
        load_id     = '0;
        load_status = ST_NOT_FUTURE;
      end else if (!free_hit) begin
        load_id     = '0;
        load_status = ST_FULL;
      end else begin
        load_id     = next_id_q;
        load_status = ST_ADDED;
      end
    end else if (cmd_i.del_emit) begin
      load_last   = 1'b1;
      load_id     = del_found_q ? target_q : '0;
      load_status = del_found_q ? ST_DELETED : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_id_q     <= load_id;
      out_status_q <= load_status;
      out_last_q   <= load_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.result_id = out_id_q;
  assign out_o.status    = out_status_q;
  assign out_o.last      = out_last_q;

  assign stat_o.in_valid   = in_i.valid;
  assign stat_o.in_cmd     = in_i.command;
  assign stat_o.out_free   = out_free;
  assign stat_o.scan_done  = (scan_addr_q == CW'(TIMER_SLOTS)) && !rd_vld_q;
  assign stat_o.best_found = best_found_q;
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.fire_full  = (fire_cnt_q == FireCntW'(MaxFires - 1));

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result word loaded over an untaken one");

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.do_add, cmd_i.del_emit, cmd_i.fire_emit}))
    else $error("more than one result source in a cycle");

  a_arm_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_arm |=> valid_q[$past(free_idx)])
    else $error("armed slot not marked in use");

  a_upd_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire_upd |-> best_found_q)
    else $error("fire update without an expired timer");

  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != '0)
    else $error("id counter reached zero");
`endif

endmodule

### tb/timer_expiry_scheduler_checker.sv
`timescale 1ns / 100ps

module timer_expiry_scheduler_checker #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  tes_in_if                       in_mon,
  tes_out_if                      out_mon,
  output int                      fails_o,
  output int                      pending_o,
  output logic [tes_pkg::IdW-1:0] next_id_o
);
  import tes_pkg::*;

  typedef struct packed {
    logic [IdW-1:0] id;
    status_e        status;
    logic           last;
  } result_t;

  result_t          due_results[$];
  logic             armed    [TIMER_SLOTS];
  logic [IdW-1:0]   owner_id [TIMER_SLOTS];
  logic [TimeW-1:0] due_at   [TIMER_SLOTS];
  logic [IvW-1:0]   interval [TIMER_SLOTS];
  logic [TimeW-1:0] now_ticks;
  logic [IdW-1:0]   id_counter;

  function automatic result_t result_word(logic [IdW-1:0] id, status_e st, logic last);
    result_t w;
    w.id     = id;
    w.status = st;
    w.last   = last;
    return w;
  endfunction

  task automatic expect_word(input logic [IdW-1:0] id,
                             input status_e        st,
                             input logic           last);
    due_results.insert(due_results.size(), result_word(id, st, last));
  endtask

  task automatic apply_timer_command(input cmd_e             cmd,
                                     input logic [IvW-1:0]   delay,
                                     input logic [IvW-1:0]   period,
                                     input logic [TimeW-1:0] mark,
                                     input logic [IdW-1:0]   target);
    int               slot;
    int               best;
    int               fired;
    logic             hit;
    logic [TimeW-1:0] ahead;
    logic [TimeW-1:0] age;
    logic [TimeW-1:0] best_age;
    slot     = -1;
    best     = 0;
    fired    = 0;
    hit      = 1'b0;
    best_age = '0;
    case (cmd)
      CMD_ADD, CMD_ADD_AT: begin
        ahead = mark - now_ticks;
        // absolute mark must lie strictly ahead, wrap-aware
        if (cmd == CMD_ADD_AT && (ahead == '0 || ahead[TimeW-1])) begin
          expect_word('0, ST_NOT_FUTURE, 1'b1);
        end else begin
          for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!armed[i]) slot = i;
          end
          if (slot < 0) begin
            expect_word('0, ST_FULL, 1'b1);
          end else begin
            armed[slot]    = 1'b1;
            owner_id[slot] = id_counter;
            if (cmd == CMD_ADD_AT) begin
              due_at[slot]   = mark;
              interval[slot] = '0;
            end else begin
              due_at[slot]   = now_ticks + TimeW'(delay);
              interval[slot] = period;
            end
            expect_word(id_counter, ST_ADDED, 1'b1);
            id_counter = id_counter + IdW'(1);
            if (id_counter == '0) id_counter = IdW'(1);
          end
        end
      end
      CMD_DELETE: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (armed[i] && owner_id[i] == target) begin
            armed[i] = 1'b0;
            hit      = 1'b1;
          end
        end
        if (hit) expect_word(target, ST_DELETED, 1'b1);
        else expect_word('0, ST_NOT_FOUND, 1'b1);
      end
      default: begin
        now_ticks = now_ticks + TimeW'(1);
        // oldest expiry first, lower id on a tie
        while (best >= 0 && fired < MaxFires) begin
          best     = -1;
          best_age = '0;
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            age = now_ticks - due_at[i];
            if (armed[i] && !age[TimeW-1] &&
                (best < 0 || age > best_age ||
                 (age == best_age && owner_id[i] < owner_id[best]))) begin
              best     = i;
              best_age = age;
            end
          end
          if (best >= 0) begin
            expect_word(owner_id[best], ST_FIRED, 1'b0);
            fired++;
            if (interval[best] != '0) due_at[best] = now_ticks + TimeW'(interval[best]);
            else armed[best] = 1'b0;
          end
        end
        if (fired > 0) begin
          due_results[due_results.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      due_results.delete();
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        armed[i] = 1'b0;
      end
      now_ticks  = '0;
      id_counter = IdW'(1);
      pending_o <= 0;
      next_id_o <= IdW'(1);
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          fails_o++;
          if (fails_o <= 100) begin
            $display("%0t: result word with nothing expected: id %0d status %0d last %0b",
                     $time, out_mon.result_id, out_mon.status, out_mon.last);
          end
        end else begin
          want = due_results.pop_front();
          if (out_mon.result_id !== want.id || out_mon.status !== want.status ||
              out_mon.last !== want.last) begin
            fails_o++;
            if (fails_o <= 100) begin
              $display("%0t: expected id %0d status %0d last %0b, got id %0d status %0d last %0b",
                       $time, want.id, want.status, want.last,
                       out_mon.result_id, out_mon.status, out_mon.last);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_timer_command(in_mon.command, in_mon.delay_ms, in_mon.period_ms,
                            in_mon.absolute_time, in_mon.target_id);
      end
      pending_o <= due_results.size();
      next_id_o <= id_counter;
    end
  end

endmodule

### tb/timer_expiry_scheduler_tb.sv
`timescale 1ns / 100ps

module timer_expiry_scheduler_tb;
  import tes_pkg::*;

  localparam int unsigned SLOTS         = 16;
  localparam int          RANDOM_ITEMS  = 400;
  localparam int          STALL_LIMIT   = 5000;
  localparam int          SETTLE_CYCLES = 40;

  logic             clk;
  logic             rst_n;
  int               fails;
  int               pending;
  logic [IdW-1:0]   next_id;
  int               sink_hold;
  bit               no_idle;
  logic [TimeW-1:0] now_mark;
  int               items_sent;

  tes_in_if  in_if ();
  tes_out_if out_if ();

  timer_expiry_scheduler #(
    .TIMER_SLOTS(SLOTS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  timer_expiry_scheduler_checker #(
    .TIMER_SLOTS(SLOTS)
  ) expiry_check (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .fails_o  (fails),
    .pending_o(pending),
    .next_id_o(next_id)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [IvW-1:0] any_interval();
    logic [31:0] w;
    w = $urandom;
    return w[IvW-1:0];
  endfunction

  function automatic logic [IdW-1:0] any_id();
    logic [31:0] w;
    w = $urandom;
    return w[IdW-1:0];
  endfunction

  task automatic send_word(input cmd_e             cmd,
                           input logic [IvW-1:0]   delay,
                           input logic [IvW-1:0]   period,
                           input logic [TimeW-1:0] mark,
                           input logic [IdW-1:0]   target);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid         <= 1'b1;
    in_if.command       <= cmd;
    in_if.delay_ms      <= delay;
    in_if.period_ms     <= period;
    in_if.absolute_time <= mark;
    in_if.target_id     <= target;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (cmd == CMD_TICK) now_mark = now_mark + TimeW'(1);
    items_sent++;
  endtask

  // stop offering and wait for every expected word
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic random_word();
    int               r;
    logic [IvW-1:0]   delay;
    logic [IvW-1:0]   period;
    logic [TimeW-1:0] mark;
    logic [IdW-1:0]   target;
    // unused fields carry noise
    delay  = any_interval();
    period = any_interval();
    mark   = $urandom;
    target = any_id();
    r      = $urandom_range(0, 99);
    if (r < 30) begin
      r = $urandom_range(0, 9);
      if (r < 7) delay = IvW'($urandom_range(0, 6));
      else if (r < 9) delay = IvW'($urandom_range(7, 40));
      r = $urandom_range(0, 19);
      if (r < 13) period = '0;
      else if (r < 18) period = IvW'($urandom_range(1, 6));
      send_word(CMD_ADD, delay, period, mark, target);
    end else if (r < 45) begin
      r = $urandom_range(0, 19);
      if (r < 12) mark = now_mark + TimeW'($urandom_range(1, 8));
      else if (r < 15) mark = now_mark - TimeW'($urandom_range(0, 3));
      else if (r < 17) mark = now_mark + (r == 15 ? 32'h7FFF_FFFF : 32'h8000_0000);
      send_word(CMD_ADD_AT, delay, period, mark, target);
    end else if (r < 60) begin
      r = $urandom_range(0, 9);
      if (r < 6) target = next_id - IdW'($urandom_range(1, 24));
      else if (r < 7) target = '0;
      send_word(CMD_DELETE, delay, period, mark, target);
    end else begin
      send_word(CMD_TICK, delay, period, mark, target);
    end
  endtask

  // a run of adds expiring on two neighbouring ticks, then enough ticks to fire them all
  task automatic fill_and_flush();
    logic [IvW-1:0] lag;
    lag = IvW'($urandom_range(0, 3));
    repeat (SLOTS) begin
      send_word(CMD_ADD, lag + IvW'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? IvW'($urandom_range(1, 3)) : '0,
                $urandom, any_id());
    end
    repeat (int'(lag) + 2) send_word(CMD_TICK, any_interval(), any_interval(), $urandom, any_id());
  endtask

  // result side
  initial begin
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_if.ready <= 1'b0;
        sink_hold = sink_hold - 1;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall = pick_gap();
      end
    end
  end

  // ends the run when nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("** timer_expiry_scheduler: FAILED **");
    $finish;
  end

  initial begin
    int             stop_at;
    int             start;
    bit             paused;
    bit             pressed;
    rst_n               = 1'b0;
    sink_hold           = 0;
    no_idle             = 1'b0;
    now_mark            = '0;
    items_sent          = 0;
    paused              = 1'b0;
    pressed             = 1'b0;
    in_if.valid         = 1'b0;
    in_if.command       = CMD_TICK;
    in_if.delay_ms      = '0;
    in_if.period_ms     = '0;
    in_if.absolute_time = '0;
    in_if.target_id     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table: delete of id zero, tick with nothing due
    send_word(CMD_DELETE, '0, '0, '0, '0);
    send_word(CMD_TICK, '1, '1, '1, '1);
    // one-shot due now, every-tick repeat, longest delay and interval
    send_word(CMD_ADD, '0, '0, '0, '0);
    send_word(CMD_ADD, '0, IvW'(1), '0, '0);
    send_word(CMD_ADD, '1, '1, '1, '1);
    // marks at now, half the range away, all ones, edge of the window, next tick
    send_word(CMD_ADD_AT, '0, '0, now_mark, '0);
    send_word(CMD_ADD_AT, '0, '0, now_mark + 32'h8000_0000, '0);
    send_word(CMD_ADD_AT, '0, '0, '1, '0);
    send_word(CMD_ADD_AT, '1, '1, now_mark + 32'h7FFF_FFFF, '1);
    send_word(CMD_ADD_AT, '0, '0, now_mark + TimeW'(1), '0);
    send_word(CMD_DELETE, '0, '0, '0, IdW'(3));
    send_word(CMD_DELETE, '0, '0, '0, '1);
    // two timers tie on expiry, a third due one tick later
    send_word(CMD_TICK, '0, '0, '0, '0);
    // fill up, then rejections for a full table and for a mark at the current time
    repeat (SLOTS - 2) send_word(CMD_ADD, IvW'(1), '0, '0, '0);
    send_word(CMD_ADD, IvW'(1), '0, '0, '0);
    send_word(CMD_ADD_AT, '0, '0, now_mark + 32'd5, '0);
    send_word(CMD_ADD_AT, '0, '0, now_mark, '0);
    send_word(CMD_DELETE, '0, '0, '0, IdW'(4));
    send_word(CMD_ADD, IvW'(1), '0, '0, '0);
    // every slot fires on one tick
    send_word(CMD_TICK, '0, '0, '0, '0);

    start   = items_sent;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      no_idle = (items_sent >= start + 150 && items_sent < start + 220);
      if (!paused && items_sent >= start + 120) begin
        paused = 1'b1;
        drain();
      end
      if (!pressed && items_sent >= start + 260) begin
        pressed   = 1'b1;
        sink_hold = 300;
      end
      if ($urandom_range(0, 29) == 0) fill_and_flush();
      else random_word();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("** timer_expiry_scheduler: PASSED **");
    end else begin
      $display("** timer_expiry_scheduler: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tes_pkg.sv
hw/rtl/tes_in_if.sv
hw/rtl/tes_out_if.sv
hw/rtl/tes_ctrl.sv
hw/rtl/tes_datapath.sv
hw/rtl/timer_expiry_scheduler.sv
tb/timer_expiry_scheduler_checker.sv
tb/timer_expiry_scheduler_tb.sv
